/* rtl/core/sbe_pkg.sv */
// shared types, constants and opcodes for the stack bytecode executor
`default_nettype none
package sbe_pkg;
    localparam int STACK_DEPTH_DEF  = 256;
    localparam int BANK_ENTRIES_DEF = 8;
    localparam int NUM_BANKS        = 8;

    typedef enum logic [7:0] {
        OP_HALT  = 8'd0,  OP_PUSH  = 8'd1,  OP_DEL   = 8'd2,  OP_CLR   = 8'd3,
        OP_ADD   = 8'd4,  OP_SUB   = 8'd5,  OP_MUL   = 8'd6,  OP_DIV   = 8'd7,
        OP_EMIT  = 8'd8,  OP_CHAR  = 8'd9,  OP_PEEK  = 8'd10, OP_JMP   = 8'd11,
        OP_JZ    = 8'd12, OP_JNZ   = 8'd13, OP_EQ    = 8'd14, OP_NE    = 8'd15,
        OP_LT    = 8'd16, OP_GT    = 8'd17, OP_LE    = 8'd18, OP_GE    = 8'd19,
        OP_DUP   = 8'd20, OP_SWAP  = 8'd21, OP_OVER  = 8'd22, OP_NOP   = 8'd23,
        OP_STORE = 8'd24, OP_LOAD  = 8'd25
    } opcode_t;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_UNK  = 2'd3;

    localparam logic [1:0] OK_NONE = 2'd0;
    localparam logic [1:0] OK_DEC  = 2'd1;
    localparam logic [1:0] OK_CHAR = 2'd2;
    localparam logic [1:0] OK_DECN = 2'd3;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  immediate;
        logic [2:0]  bank;
        logic [2:0]  slot;
        logic [15:0] instr_addr;
    } instr_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         out_kind;
        logic signed [31:0] out_value;
        logic [15:0]        next_addr;
        logic               overflow;
        logic               underflow;
    } result_t;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] q;
    } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/core/sbe_stream_if.sv */
// valid/ready channel carrying one payload
`default_nettype none
interface sbe_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/sbe_divider.sv */
// signed restoring divider, one quotient bit per cycle
`default_nettype none
module sbe_divider (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sbe_pkg::div_req_t req,
    output sbe_pkg::div_rsp_t    rsp
);
    import sbe_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic        done_reg;

    logic [32:0] trial;
    logic [31:0] ma, mb;

    always_comb
    begin
        ma    = req.a[31] ? (32'd0 - req.a) : req.a;
        mb    = req.b[31] ? (32'd0 - req.b) : req.b;
        trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= ma;
                den_reg  <= mb;
                neg_reg  <= req.a[31] ^ req.b[31];
            end
            else if (busy_reg)
            begin
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[30:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = neg_reg ? (32'd0 - quo_reg) : quo_reg;
endmodule
`default_nettype wire

/* rtl/core/stack_bytecode_executor_unit.sv */
// top level: sequencer around the operand stack memory and register file memory
`default_nettype none
// stack bytecode executor: each input transaction is one decoded instruction,
// each output transaction its result (status, print value, next address,
// overflow and underflow flags). the operand stack and the register file are
// synchronous memories with a registered read; a sequencer pops the operands
// one memory read at a time, computes, then pushes the results one write per
// cycle. divide waits for the bit-serial divider. the result waits in its own
// output register, so the next instruction can be taken while a result is
// stalled; a stall longer than one instruction holds the sequencer in its
// output state. the operand stack holds undefined data after reset and needs
// no clearing pass; the register file is cleared by a sweep over all
// 8*BANK_ENTRIES entries after reset, during which no instruction is taken.
// once a halt, divide by zero or unknown opcode is seen, every later
// instruction answers halted until reset.
module stack_bytecode_executor_unit #(
    parameter int STACK_DEPTH  = sbe_pkg::STACK_DEPTH_DEF,
    parameter int BANK_ENTRIES = sbe_pkg::BANK_ENTRIES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sbe_stream_if.sink     in_if,
    sbe_stream_if.source   out_if
);
    import sbe_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int RF_DEPTH = NUM_BANKS * BANK_ENTRIES;
    localparam int RAW = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
    localparam int SW  = (BANK_ENTRIES > 1) ? $clog2(BANK_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_POPWAIT, S_POP, S_MUL, S_DIVWAIT,
        S_EXEC, S_PUSH, S_OUT
    } state_t;

    // memories
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [15:0] rf_mem [RF_DEPTH];

    state_t        state_reg;
    instr_t        ins_reg;
    logic [CW-1:0] cnt_reg;
    logic          stopped_reg;
    logic [RAW-1:0] clr_reg;
    logic [1:0]    npop_reg;    // operands still to pop
    logic [31:0]   b_reg, a_reg, r_reg;
    logic [31:0]   push_reg [3];
    logic [1:0]    npush_reg, pidx_reg;
    logic          ovf_reg, unf_reg;
    result_t       res_reg;
    result_t       out_reg;
    logic          ovalid_reg;
    logic [31:0]   srd_reg;
    logic [15:0]   rrd_reg;
    logic          rf_ok_reg;
    logic [31:0]   mul_reg;
    div_req_t      dreq;
    div_rsp_t      drsp;

    sbe_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic slot_ok;
    logic [RAW-1:0] ridx;
    logic [RAW+SW:0] ridx_w;
    always_comb
    begin
        slot_ok = 32'(ins_reg.slot) < 32'(BANK_ENTRIES);
        ridx_w  = (RAW+SW+1)'(ins_reg.bank) * (RAW+SW+1)'(BANK_ENTRIES)
                + (RAW+SW+1)'(ins_reg.slot);
        ridx    = ridx_w[RAW-1:0];
    end

    // stack read port: address is top-1 of current count
    logic [CW-1:0] cm1;
    assign cm1 = cnt_reg - CW'(1);
    always_ff @(posedge clk)
    begin
        srd_reg <= stack_mem[cm1[SAW-1:0]];
        if (state_reg == S_PUSH && npush_reg != pidx_reg && cnt_reg < CW'(STACK_DEPTH))
            stack_mem[cnt_reg[SAW-1:0]] <= push_reg[pidx_reg];
    end

    always_ff @(posedge clk)
    begin
        rrd_reg <= rf_mem[ridx];
        if (state_reg == S_CLEAR)
            rf_mem[clr_reg] <= '0;
        else if (state_reg == S_EXEC && ins_reg.cmd == OP_STORE && slot_ok && !stopped_reg)
            rf_mem[ridx] <= a_reg[15:0];
    end

    logic is_less_ab, is_less_ba;
    assign is_less_ab = $signed(a_reg) < $signed(b_reg);
    assign is_less_ba = $signed(b_reg) < $signed(a_reg);

    assign in_if.ready = (state_reg == S_IDLE);
    assign out_if.valid = ovalid_reg;
    assign out_if.data  = out_reg;

    always_comb
    begin
        dreq.start = (state_reg == S_MUL) && (ins_reg.cmd == OP_DIV) && (b_reg != 32'd0);
        dreq.a = a_reg;
        dreq.b = b_reg;
    end

    always_ff @(posedge clk)
        mul_reg <= a_reg * b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            // a result taken while no new one is loaded empties the output
            if (ovalid_reg && out_if.ready && state_reg != S_OUT)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + RAW'(1);
                    if (32'(clr_reg) == RF_DEPTH - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_if.valid)
                    begin
                        ins_reg   <= in_if.data;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    ovf_reg    <= 1'b0;
                    unf_reg    <= 1'b0;
                    a_reg      <= '0;
                    b_reg      <= '0;
                    npush_reg  <= '0;
                    pidx_reg   <= '0;
                    rf_ok_reg  <= slot_ok;
                    if (stopped_reg)
                        npop_reg <= 2'd0;
                    else
                    begin
                        priority case (ins_reg.cmd)
                            OP_DEL, OP_EMIT, OP_CHAR, OP_PEEK, OP_JZ, OP_JNZ,
                            OP_DUP, OP_STORE:
                                npop_reg <= 2'd1;
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_LT,
                            OP_GT, OP_LE, OP_GE, OP_SWAP, OP_OVER:
                                npop_reg <= 2'd2;
                            default:
                                npop_reg <= 2'd0;
                        endcase
                    end
                    state_reg <= S_POPWAIT;
                end
                S_POPWAIT:
                    state_reg <= (npop_reg == 2'd0) ? S_MUL : S_POP;
                S_POP:
                begin
                    // srd_reg holds entry at count-1; pop 1 of 2 ends in b_reg
                    if (cnt_reg == '0)
                    begin
                        unf_reg <= 1'b1;
                        a_reg   <= '0;
                        b_reg   <= a_reg;
                    end
                    else
                    begin
                        a_reg <= srd_reg;
                        b_reg <= a_reg;
                        if (ins_reg.cmd != OP_PEEK)
                            cnt_reg <= cm1;
                    end
                    npop_reg   <= npop_reg - 2'd1;
                    state_reg  <= S_POPWAIT;
                end
                S_MUL:
                begin
                    // single pop leaves its operand in a_reg
                    if (dreq.start)
                        state_reg <= S_DIVWAIT;
                    else
                        state_reg <= S_EXEC;
                end
                S_DIVWAIT:
                    if (drsp.done)
                        state_reg <= S_EXEC;
                S_EXEC:
                begin
                    res_reg.status    <= ST_RUN;
                    res_reg.out_kind  <= OK_NONE;
                    res_reg.out_value <= '0;
                    res_reg.next_addr <= ins_reg.instr_addr + 16'd1;
                    state_reg <= S_PUSH;
                    if (stopped_reg)
                    begin
                        res_reg.status    <= ST_HALT;
                        res_reg.next_addr <= ins_reg.instr_addr;
                    end
                    else
                    begin
                        priority case (ins_reg.cmd)
                            OP_HALT:
                            begin
                                res_reg.status    <= ST_HALT;
                                res_reg.next_addr <= ins_reg.instr_addr;
                                stopped_reg       <= 1'b1;
                            end
                            OP_PUSH:
                            begin
                                push_reg[0] <= {24'd0, ins_reg.immediate};
                                npush_reg   <= 2'd1;
                                res_reg.next_addr <= ins_reg.instr_addr + 16'd2;
                            end
                            OP_DEL, OP_NOP: ;
                            OP_CLR: cnt_reg <= '0;
                            OP_ADD:
                            begin
                                push_reg[0] <= a_reg + b_reg; npush_reg <= 2'd1;
                            end
                            OP_SUB:
                            begin
                                push_reg[0] <= a_reg - b_reg; npush_reg <= 2'd1;
                            end
                            OP_MUL:
                            begin
                                push_reg[0] <= mul_reg; npush_reg <= 2'd1;
                            end
                            OP_DIV:
                            begin
                                if (b_reg == 32'd0)
                                begin
                                    res_reg.status    <= ST_DIVZ;
                                    res_reg.next_addr <= ins_reg.instr_addr;
                                    stopped_reg       <= 1'b1;
                                end
                                else
                                begin
                                    push_reg[0] <= drsp.q; npush_reg <= 2'd1;
                                end
                            end
                            OP_EMIT:
                            begin
                                res_reg.out_kind <= OK_DEC; res_reg.out_value <= a_reg;
                            end
                            OP_CHAR:
                            begin
                                res_reg.out_kind  <= OK_CHAR;
                                res_reg.out_value <= {24'd0, a_reg[7:0]};
                            end
                            OP_PEEK:
                            begin
                                res_reg.out_kind <= OK_DECN; res_reg.out_value <= a_reg;
                            end
                            OP_JMP:
                                res_reg.next_addr <= {8'd0, ins_reg.immediate};
                            OP_JZ:
                                res_reg.next_addr <= (a_reg == 32'd0)
                                    ? {8'd0, ins_reg.immediate} : ins_reg.instr_addr + 16'd2;
                            OP_JNZ:
                                res_reg.next_addr <= (a_reg != 32'd0)
                                    ? {8'd0, ins_reg.immediate} : ins_reg.instr_addr + 16'd2;
                            OP_EQ:
                            begin
                                push_reg[0] <= {31'd0, a_reg == b_reg}; npush_reg <= 2'd1;
                            end
                            OP_NE:
                            begin
                                push_reg[0] <= {31'd0, a_reg != b_reg}; npush_reg <= 2'd1;
                            end
                            OP_LT:
                            begin
                                push_reg[0] <= {31'd0, is_less_ab}; npush_reg <= 2'd1;
                            end
                            OP_GT:
                            begin
                                push_reg[0] <= {31'd0, is_less_ba}; npush_reg <= 2'd1;
                            end
                            OP_LE:
                            begin
                                push_reg[0] <= {31'd0, !is_less_ba}; npush_reg <= 2'd1;
                            end
                            OP_GE:
                            begin
                                push_reg[0] <= {31'd0, !is_less_ab}; npush_reg <= 2'd1;
                            end
                            OP_DUP:
                            begin
                                push_reg[0] <= a_reg; push_reg[1] <= a_reg;
                                npush_reg <= 2'd2;
                            end
                            OP_SWAP:
                            begin
                                push_reg[0] <= b_reg; push_reg[1] <= a_reg;
                                npush_reg <= 2'd2;
                            end
                            OP_OVER:
                            begin
                                push_reg[0] <= a_reg; push_reg[1] <= b_reg;
                                push_reg[2] <= a_reg; npush_reg <= 2'd3;
                            end
                            OP_STORE:
                                res_reg.next_addr <= ins_reg.instr_addr + 16'd3;
                            OP_LOAD:
                            begin
                                push_reg[0] <= rf_ok_reg ? {16'd0, rrd_reg} : 32'd0;
                                npush_reg   <= 2'd1;
                                res_reg.next_addr <= ins_reg.instr_addr + 16'd3;
                            end
                            default:
                            begin
                                res_reg.status    <= ST_UNK;
                                res_reg.next_addr <= ins_reg.instr_addr;
                                stopped_reg       <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PUSH:
                begin
                    if (npush_reg != pidx_reg)
                    begin
                        if (cnt_reg < CW'(STACK_DEPTH))
                            cnt_reg <= cnt_reg + CW'(1);
                        else
                            ovf_reg <= 1'b1;
                        pidx_reg <= pidx_reg + 2'd1;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // load the output register once the previous result is gone
                    if (!ovalid_reg || out_if.ready)
                    begin
                        out_reg <= {res_reg.status, res_reg.out_kind, res_reg.out_value,
                                    res_reg.next_addr, ovf_reg, unf_reg};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
